>>> design/cfes_pkg.sv
// Shared constants, codes and control types for the coverage-favoured entry scheduler.
`default_nettype none

package cfes_pkg;

  // Table sizes
  localparam int unsigned MAX_ENTRIES = 1024;
  localparam int unsigned MAP_SIZE    = 65536;

  // Derived widths
  localparam int unsigned ID_W    = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned MAP_W   = $clog2(MAP_SIZE);

  // Payload field widths
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned SIZE_W     = 21;
  localparam int unsigned TIME_W     = 24;
  localparam int unsigned HIT_W      = 16;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned ENTRY_ID_W = 10;
  localparam int unsigned COST_W     = SIZE_W + TIME_W;

  // Request selector codes
  localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_HIT   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SCHED = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NO_ENTRY = 2'd3;

  // One winner-table word: valid mark plus entry id
  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] id;
  } win_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic                load_req;   // capture request payload
    logic                win_clr;    // invalidate winner at sweep index, advance
    logic                win_hit_rd; // address winner table with hit index
    logic                win_hit_wr; // compare and maybe replace winner
    logic                ent_zero;   // restart entry sweep index
    logic                rc_begin;   // clear pending count
    logic                fav_clr;    // clear favoured mark at entry index, advance
    logic                fav_rd_win; // address entry marks with winner id
    logic                rc_upd;     // favour current winner, advance map index
    logic                rc_end;     // winners now culled
    logic                add;        // append entry
    logic                adv;        // advance cursor round-robin
    logic                srch;       // one step of the favoured search
    logic                fin;        // mark cursor entry fuzzed, build result
    logic                res_err;    // build result with no entry
    logic [STATUS_W-1:0] err_status;
    logic                out_load;   // move result into output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic count_zero;
    logic count_full;
    logic changed;
    logic pending_nz;
    logic map_last;
    logic ent_last;
    logic srch_found;
    logic srch_spent;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> design/cfes_req_if.sv
// Request channel: valid/ready handshake and request payload.
`default_nettype none

interface cfes_req_if import cfes_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [SIZE_W-1:0] testcase_size;
  logic [TIME_W-1:0] exec_time_us;
  logic [HIT_W-1:0]  hit_index;

  modport source (output valid, func, testcase_size, exec_time_us, hit_index, input ready);
  modport sink   (input valid, func, testcase_size, exec_time_us, hit_index, output ready);
endinterface

`default_nettype wire

>>> design/cfes_rsp_if.sv
// Result channel: valid/ready handshake and result payload.
`default_nettype none

interface cfes_rsp_if import cfes_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [ENTRY_ID_W-1:0] entry_id;
  logic                  was_favored;

  modport source (output valid, status, entry_id, was_favored, input ready);
  modport sink   (input valid, status, entry_id, was_favored, output ready);
endinterface

`default_nettype wire

>>> design/cfes_ctrl.sv
// Controller state machine sequencing table clears, culls, searches and results.
`default_nettype none

module cfes_ctrl import cfes_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  input  wire logic [FUNC_W-1:0] req_func_i,
  output logic                   req_ready_o,
  input  wire sts_t              sts_i,
  output cmd_t                   cmd_o
);

  localparam logic [3:0] S_CLR     = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_ADD     = 4'd2;
  localparam logic [3:0] S_HIT_RW  = 4'd3;
  localparam logic [3:0] S_HIT_RC  = 4'd4;
  localparam logic [3:0] S_HIT_CMP = 4'd5;
  localparam logic [3:0] S_RC_CLR  = 4'd6;
  localparam logic [3:0] S_RC_FAV  = 4'd7;
  localparam logic [3:0] S_RC_UPD  = 4'd8;
  localparam logic [3:0] S_ADV     = 4'd9;
  localparam logic [3:0] S_SR_CHK  = 4'd10;
  localparam logic [3:0] S_FIN     = 4'd11;
  localparam logic [3:0] S_DONE    = 4'd12;

  logic [3:0] state_q, state_d;
  logic       req_fire;

  assign req_ready_o = (state_q == S_IDLE);
  assign req_fire    = req_valid_i && req_ready_o;

  // Decode state and status into datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.err_status = ST_OK;
    unique case (state_q)
      S_CLR: begin
        cmd_o.win_clr = 1'b1;
        if (sts_i.map_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_fire) begin
          cmd_o.load_req = 1'b1;
          priority case (req_func_i)
            FUNC_ADD: begin
              if (sts_i.count_full) begin
                cmd_o.res_err    = 1'b1;
                cmd_o.err_status = ST_FULL;
                state_d          = S_DONE;
              end else begin
                state_d = S_ADD;
              end
            end
            FUNC_HIT: begin
              if (sts_i.count_zero) begin
                cmd_o.res_err    = 1'b1;
                cmd_o.err_status = ST_NO_ENTRY;
                state_d          = S_DONE;
              end else begin
                state_d = S_HIT_RW;
              end
            end
            FUNC_SCHED: begin
              if (sts_i.count_zero) begin
                cmd_o.res_err    = 1'b1;
                cmd_o.err_status = ST_EMPTY;
                state_d          = S_DONE;
              end else if (sts_i.changed) begin
                cmd_o.ent_zero = 1'b1;
                cmd_o.rc_begin = 1'b1;
                state_d        = S_RC_CLR;
              end else begin
                state_d = S_ADV;
              end
            end
            default: begin
              // unused selector: answer an all-zero result
              cmd_o.res_err = 1'b1;
              state_d       = S_DONE;
            end
          endcase
        end
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = S_DONE;
      end
      S_HIT_RW: begin
        cmd_o.win_hit_rd = 1'b1;
        state_d          = S_HIT_RC;
      end
      S_HIT_RC: begin
        cmd_o.win_hit_rd = 1'b1;
        state_d          = S_HIT_CMP;
      end
      S_HIT_CMP: begin
        cmd_o.win_hit_wr = 1'b1;
        state_d          = S_DONE;
      end
      S_RC_CLR: begin
        cmd_o.fav_clr = 1'b1;
        if (sts_i.ent_last) state_d = S_RC_FAV;
      end
      S_RC_FAV: begin
        cmd_o.fav_rd_win = 1'b1;
        state_d          = S_RC_UPD;
      end
      S_RC_UPD: begin
        cmd_o.rc_upd = 1'b1;
        if (sts_i.map_last) begin
          cmd_o.rc_end = 1'b1;
          state_d      = S_ADV;
        end else begin
          state_d = S_RC_FAV;
        end
      end
      S_ADV: begin
        cmd_o.adv = 1'b1;
        state_d   = sts_i.pending_nz ? S_SR_CHK : S_FIN;
      end
      S_SR_CHK: begin
        cmd_o.srch = 1'b1;
        if (sts_i.srch_found || sts_i.srch_spent) state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state; start in the winner-table clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> design/cfes_dp.sv
// Datapath: entry and winner memories, counters, cursor and result registers.
`default_nettype none

module cfes_dp import cfes_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cmd_t              cmd_i,
  output sts_t                   sts_o,
  input  wire logic [SIZE_W-1:0] req_size_i,
  input  wire logic [TIME_W-1:0] req_time_i,
  input  wire logic [HIT_W-1:0]  req_hit_i,
  output logic                   rsp_valid_o,
  input  wire logic              rsp_ready_i,
  output logic [STATUS_W-1:0]    rsp_status_o,
  output logic [ENTRY_ID_W-1:0]  rsp_entry_id_o,
  output logic                   rsp_was_favored_o
);

  // Entry and winner stores
  logic [COST_W-1:0] cost_mem [MAX_ENTRIES];
  logic              fav_mem  [MAX_ENTRIES];
  logic              fuz_mem  [MAX_ENTRIES];
  win_t              win_mem  [MAP_SIZE];

  // Control state
  logic [CNT_W-1:0] count_q, count_d;
  logic [ID_W-1:0]  cursor_q, cursor_d;
  logic             cur_v_q, cur_v_d;
  logic [CNT_W-1:0] pend_q, pend_d;
  logic             chg_q, chg_d;
  logic [MAP_W-1:0] map_idx_q, map_idx_d;
  logic [ID_W-1:0]  ent_idx_q, ent_idx_d;
  logic [CNT_W-1:0] steps_q, steps_d;
  logic             out_valid_q;

  // Payload registers
  logic [SIZE_W-1:0]     size_q;
  logic [TIME_W-1:0]     time_q;
  logic [HIT_W-1:0]      hit_q;
  logic [COST_W-1:0]     newest_cost_q;
  logic [COST_W-1:0]     cost_rd_q;
  logic                  fav_rd_q;
  logic                  fuz_rd_q;
  win_t                  win_rd_q;
  logic [STATUS_W-1:0]   res_status_q, res_status_d;
  logic [ID_W-1:0]       res_id_q, res_id_d;
  logic                  res_fav_q, res_fav_d;
  logic [STATUS_W-1:0]   out_status_q;
  logic [ENTRY_ID_W-1:0] out_id_q;
  logic                  out_fav_q;

  // Memory port controls
  logic             cost_we;
  logic [COST_W-1:0] product;
  logic             fav_we, fav_wdata, fuz_we;
  logic [ID_W-1:0]  fav_waddr, fuz_waddr, mark_raddr;
  logic             win_we;
  logic [MAP_W-1:0] win_waddr, win_raddr, hit_addr;
  win_t             win_wdata;

  logic [ID_W-1:0]  newest_id;
  logic             hit_in_map;
  logic             take;
  logic             map_last;

  function automatic logic [ID_W-1:0] next_pos(input logic [ID_W-1:0]  p,
                                               input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] inc;
    inc = CNT_W'(p) + CNT_W'(1);
    return (inc >= cnt) ? '0 : inc[ID_W-1:0];
  endfunction

  assign product    = COST_W'(size_q) * COST_W'(time_q);
  assign newest_id  = ID_W'(count_q - CNT_W'(1));
  assign hit_in_map = (32'(hit_q) < 32'(MAP_SIZE));
  assign hit_addr   = MAP_W'(hit_q);
  assign take       = !win_rd_q.valid || !(newest_cost_q > cost_rd_q);
  assign map_last   = (map_idx_q == MAP_W'(MAP_SIZE - 1));

  // Status towards the controller
  always_comb begin
    sts_o.count_zero = (count_q == '0);
    sts_o.count_full = (count_q == CNT_W'(MAX_ENTRIES));
    sts_o.changed    = chg_q;
    sts_o.pending_nz = (pend_q != '0);
    sts_o.map_last   = map_last;
    sts_o.ent_last   = (CNT_W'(ent_idx_q) == (count_q - CNT_W'(1)));
    sts_o.srch_found = fav_rd_q && !fuz_rd_q;
    sts_o.srch_spent = ((steps_q + CNT_W'(1)) == count_q);
    sts_o.out_free   = !out_valid_q || rsp_ready_i;
  end

  // Next-state and memory write selection
  always_comb begin
    count_d      = count_q;
    cursor_d     = cursor_q;
    cur_v_d      = cur_v_q;
    pend_d       = pend_q;
    chg_d        = chg_q;
    map_idx_d    = map_idx_q;
    ent_idx_d    = ent_idx_q;
    steps_d      = steps_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    res_fav_d    = res_fav_q;
    cost_we      = 1'b0;
    fav_we       = 1'b0;
    fav_waddr    = ent_idx_q;
    fav_wdata    = 1'b0;
    fuz_we       = 1'b0;
    fuz_waddr    = cursor_q;
    win_we       = 1'b0;
    win_waddr    = map_idx_q;
    win_wdata    = '0;

    // sweep the winner table to invalid
    if (cmd_i.win_clr) begin
      win_we    = 1'b1;
      map_idx_d = map_last ? '0 : map_idx_q + MAP_W'(1);
    end

    if (cmd_i.ent_zero) ent_idx_d = '0;
    if (cmd_i.rc_begin) pend_d = '0;

    // drop favoured marks of all live entries
    if (cmd_i.fav_clr) begin
      fav_we    = 1'b1;
      fav_waddr = ent_idx_q;
      ent_idx_d = ent_idx_q + ID_W'(1);
    end

    // append a new entry with fresh marks
    if (cmd_i.add) begin
      cost_we      = 1'b1;
      fav_we       = 1'b1;
      fav_waddr    = count_q[ID_W-1:0];
      fuz_we       = 1'b1;
      fuz_waddr    = count_q[ID_W-1:0];
      count_d      = count_q + CNT_W'(1);
      res_status_d = ST_OK;
      res_id_d     = count_q[ID_W-1:0];
      res_fav_d    = 1'b0;
    end

    // replace the winner when the newest entry costs no more
    if (cmd_i.win_hit_wr) begin
      if (hit_in_map && take) begin
        win_we          = 1'b1;
        win_waddr       = hit_addr;
        win_wdata.valid = 1'b1;
        win_wdata.id    = newest_id;
        chg_d           = 1'b1;
      end
      res_status_d = ST_OK;
      res_id_d     = newest_id;
      res_fav_d    = 1'b0;
    end

    // favour the winner once and count it if still unfuzzed
    if (cmd_i.rc_upd) begin
      if (win_rd_q.valid && !fav_rd_q) begin
        fav_we    = 1'b1;
        fav_waddr = win_rd_q.id;
        fav_wdata = 1'b1;
        if (!fuz_rd_q) pend_d = pend_q + CNT_W'(1);
      end
      map_idx_d = map_last ? '0 : map_idx_q + MAP_W'(1);
    end

    if (cmd_i.rc_end) chg_d = 1'b0;

    // advance the cursor and start the search there
    if (cmd_i.adv) begin
      cursor_d  = cur_v_q ? next_pos(cursor_q, count_q) : '0;
      cur_v_d   = 1'b1;
      ent_idx_d = cursor_d;
      steps_d   = '0;
    end

    // test one entry; hold on a find, fall back to cursor when exhausted
    if (cmd_i.srch) begin
      if (fav_rd_q && !fuz_rd_q) begin
        cursor_d = ent_idx_q;
        pend_d   = pend_q - CNT_W'(1);
      end else if ((steps_q + CNT_W'(1)) == count_q) begin
        pend_d    = '0;
        ent_idx_d = cursor_q;
      end else begin
        ent_idx_d = next_pos(ent_idx_q, count_q);
        steps_d   = steps_q + CNT_W'(1);
      end
    end

    // mark the scheduled entry fuzzed
    if (cmd_i.fin) begin
      fuz_we       = 1'b1;
      fuz_waddr    = cursor_q;
      res_status_d = ST_OK;
      res_id_d     = cursor_q;
      res_fav_d    = fav_rd_q;
    end

    if (cmd_i.res_err) begin
      res_status_d = cmd_i.err_status;
      res_id_d     = '0;
      res_fav_d    = 1'b0;
    end
  end

  assign win_raddr  = cmd_i.win_hit_rd ? hit_addr : map_idx_d;
  assign mark_raddr = cmd_i.fav_rd_win ? win_rd_q.id : ent_idx_d;

  // Cost store
  always_ff @(posedge clk_i) begin
    if (cost_we) cost_mem[count_q[ID_W-1:0]] <= product;
    cost_rd_q <= cost_mem[win_rd_q.id];
  end

  // Favoured mark store
  always_ff @(posedge clk_i) begin
    if (fav_we) fav_mem[fav_waddr] <= fav_wdata;
    fav_rd_q <= fav_mem[mark_raddr];
  end

  // Fuzzed mark store
  always_ff @(posedge clk_i) begin
    if (fuz_we) fuz_mem[fuz_waddr] <= !cmd_i.add;
    fuz_rd_q <= fuz_mem[mark_raddr];
  end

  // Winner table
  always_ff @(posedge clk_i) begin
    if (win_we) win_mem[win_waddr] <= win_wdata;
    win_rd_q <= win_mem[win_raddr];
  end

  // Request, cost and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      size_q <= req_size_i;
      time_q <= req_time_i;
      hit_q  <= req_hit_i;
    end
    if (cost_we) newest_cost_q <= product;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    res_fav_q    <= res_fav_d;
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_id_q     <= ENTRY_ID_W'(res_id_q);
      out_fav_q    <= res_fav_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cursor_q    <= '0;
      cur_v_q     <= 1'b0;
      pend_q      <= '0;
      chg_q       <= 1'b0;
      map_idx_q   <= '0;
      ent_idx_q   <= '0;
      steps_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      cursor_q  <= cursor_d;
      cur_v_q   <= cur_v_d;
      pend_q    <= pend_d;
      chg_q     <= chg_d;
      map_idx_q <= map_idx_d;
      ent_idx_q <= ent_idx_d;
      steps_q   <= steps_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_valid_o       = out_valid_q;
  assign rsp_status_o      = out_status_q;
  assign rsp_entry_id_o    = out_id_q;
  assign rsp_was_favored_o = out_fav_q;

endmodule

`default_nettype wire

>>> design/coverage_favored_entry_scheduler_unit.sv
// Coverage-favoured entry scheduler: one request at a time, result in an output register.
// Requests are accepted only while idle, so a new request waits until the previous result
//   has moved into the output register; the re-cull walk of the winner table sets the worst case.
// Reset: asynchronous, active low; afterwards the winner table is swept invalid over all
//   MAP_SIZE (65536) entries while no request is accepted.
`default_nettype none

module coverage_favored_entry_scheduler_unit import cfes_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cfes_req_if.sink  req_i,
  cfes_rsp_if.source rsp_o
);

  cmd_t cmd;
  sts_t sts;
  logic req_ready;

  // Sequence each request
  cfes_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_func_i  (req_i.func),
    .req_ready_o (req_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Hold tables, counters and the result register
  cfes_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .req_size_i        (req_i.testcase_size),
    .req_time_i        (req_i.exec_time_us),
    .req_hit_i         (req_i.hit_index),
    .rsp_valid_o       (rsp_o.valid),
    .rsp_ready_i       (rsp_o.ready),
    .rsp_status_o      (rsp_o.status),
    .rsp_entry_id_o    (rsp_o.entry_id),
    .rsp_was_favored_o (rsp_o.was_favored)
  );

  assign req_i.ready = req_ready;

endmodule

`default_nettype wire

>>> bench/cfes_sched_checker.sv
// Request/result watcher for the entry scheduler: predicts each result and compares it.
`timescale 1ns / 100ps

module cfes_sched_checker import cfes_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  cfes_req_if         req_i,
  cfes_rsp_if         rsp_i,
  output int unsigned outstanding_o,
  output int unsigned fail_cnt_o
);

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [ENTRY_ID_W-1:0] entry_id;
    logic                  was_favored;
  } sched_rsp_t;

  // Predicted scheduler state
  bit [COST_W-1:0] cost_q     [MAX_ENTRIES];
  bit              fav_q      [MAX_ENTRIES];
  bit              fuzzed_q   [MAX_ENTRIES];
  bit              win_vld_q  [MAP_SIZE];
  bit [ID_W-1:0]   win_id_q   [MAP_SIZE];
  int unsigned     n_entries  = 0;
  int unsigned     cursor     = 0;
  bit              cursor_vld = 1'b0;
  int unsigned     pending    = 0;
  bit              win_dirty  = 1'b0;

  sched_rsp_t  due_results [$];
  int unsigned fails = 0;

  // Round-robin step over the live entries
  function automatic int unsigned step_on(int unsigned p);
    return (p + 1 >= n_entries) ? 0 : p + 1;
  endfunction

  // Re-cull: favour every current winner once, count those still to be fuzzed
  function automatic void refresh_favoured();
    for (int e = 0; e < MAX_ENTRIES; e++) fav_q[e] = 1'b0;
    pending = 0;
    for (int m = 0; m < MAP_SIZE; m++) begin
      if (win_vld_q[m] && !fav_q[win_id_q[m]]) begin
        fav_q[win_id_q[m]] = 1'b1;
        if (!fuzzed_q[win_id_q[m]]) pending++;
      end
    end
  endfunction

  // Apply one request to the predicted state and return its result
  function automatic sched_rsp_t outcome_of(logic [FUNC_W-1:0] f, logic [SIZE_W-1:0] sz,
                                            logic [TIME_W-1:0] tm, logic [HIT_W-1:0] hit);
    sched_rsp_t  r;
    int unsigned id;
    int unsigned p;
    int unsigned steps;
    r = '0;
    case (f)
      FUNC_ADD: begin
        if (n_entries >= MAX_ENTRIES) begin
          r.status = ST_FULL;
        end else begin
          id           = n_entries;
          cost_q[id]   = COST_W'(sz) * COST_W'(tm);
          fav_q[id]    = 1'b0;
          fuzzed_q[id] = 1'b0;
          n_entries++;
          r.entry_id   = ENTRY_ID_W'(id);
        end
      end
      FUNC_HIT: begin
        if (n_entries == 0) begin
          r.status = ST_NO_ENTRY;
        end else begin
          id         = n_entries - 1;
          r.entry_id = ENTRY_ID_W'(id);
          // equal cost takes over the map index
          if (!(win_vld_q[hit] && cost_q[id] > cost_q[win_id_q[hit]])) begin
            win_vld_q[hit] = 1'b1;
            win_id_q[hit]  = ID_W'(id);
            win_dirty      = 1'b1;
          end
        end
      end
      FUNC_SCHED: begin
        if (n_entries == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (win_dirty) begin
            refresh_favoured();
            win_dirty = 1'b0;
          end
          cursor = cursor_vld ? step_on(cursor) : 0;
          if (cursor >= n_entries) cursor = 0;
          cursor_vld = 1'b1;
          // search forward for a favoured entry not yet fuzzed
          if (pending > 0) begin
            p     = cursor;
            steps = 0;
            while (steps < n_entries && !(fav_q[p] && !fuzzed_q[p])) begin
              p = step_on(p);
              steps++;
            end
            if (steps < n_entries) begin
              cursor = p;
              pending--;
            end else begin
              pending = 0;
            end
          end
          r.entry_id       = ENTRY_ID_W'(cursor);
          r.was_favored    = fav_q[cursor];
          fuzzed_q[cursor] = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Predict on each accepted request, compare each accepted result
  always @(posedge clk_i) begin
    sched_rsp_t want;
    sched_rsp_t got;
    if (rst_ni) begin
      if (req_i.valid && req_i.ready)
        due_results.push_back(outcome_of(req_i.func, req_i.testcase_size,
                                         req_i.exec_time_us, req_i.hit_index));
      if (rsp_i.valid && rsp_i.ready) begin
        got = {rsp_i.status, rsp_i.entry_id, rsp_i.was_favored};
        if (due_results.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: result with no request pending: status=%0d id=%0d fav=%0d",
                     $realtime, got.status, got.entry_id, got.was_favored);
        end else begin
          want = due_results.pop_front();
          if (got.status !== want.status || got.entry_id !== want.entry_id ||
              got.was_favored !== want.was_favored) begin
            fails++;
            if (fails <= 10)
              $display({"%0t: result mismatch: expected status=%0d id=%0d fav=%0d,",
                        " got status=%0d id=%0d fav=%0d"},
                       $realtime, want.status, want.entry_id, want.was_favored,
                       got.status, got.entry_id, got.was_favored);
          end
        end
      end
    end
    outstanding_o <= due_results.size();
    fail_cnt_o    <= fails;
  end

endmodule

>>> bench/tb_coverage_favored_entry_scheduler_unit.sv
// Top of the entry scheduler bench: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps

module tb_coverage_favored_entry_scheduler_unit;
  import cfes_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned MAX_TC_SIZE  = 1048576;
  localparam int unsigned RUN_LIMIT    = 6_000_000;
  localparam int unsigned DRAIN_CYCLES = 200;

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              req_valid = 1'b0;
  logic [FUNC_W-1:0] req_func  = FUNC_ADD;
  logic [SIZE_W-1:0] req_size  = '0;
  logic [TIME_W-1:0] req_time  = '0;
  logic [HIT_W-1:0]  req_hit   = '0;
  logic              rsp_take  = 1'b0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycles         = 0;
  int unsigned outstanding;
  int unsigned fails;

  cfes_req_if req_if ();
  cfes_rsp_if rsp_if ();

  assign req_if.valid         = req_valid;
  assign req_if.func          = req_func;
  assign req_if.testcase_size = req_size;
  assign req_if.exec_time_us  = req_time;
  assign req_if.hit_index     = req_hit;
  assign rsp_if.ready         = rsp_take;

  coverage_favored_entry_scheduler_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  cfes_sched_checker u_watch (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_if),
    .rsp_i         (rsp_if),
    .outstanding_o (outstanding),
    .fail_cnt_o    (fails)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Stall the result side at random
  always @(posedge clk_i) begin
    rsp_take <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Abandon a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("tb_coverage_favored_entry_scheduler_unit NOT OK");
      $finish;
    end
  end

  // Half the sizes and times tiny so that ties and cheap winners turn up often
  function automatic logic [SIZE_W-1:0] rand_size();
    if ($urandom_range(1) == 0) return SIZE_W'($urandom_range(3));
    return SIZE_W'($urandom_range(MAX_TC_SIZE));
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    if ($urandom_range(1) == 0) return TIME_W'($urandom_range(3));
    return TIME_W'($urandom);
  endfunction

  // Mostly a narrow band of map indexes so entries contest them
  function automatic logic [HIT_W-1:0] rand_hit();
    if ($urandom_range(99) < 70) return HIT_W'($urandom_range(47));
    return HIT_W'($urandom);
  endfunction

  // Present one request and hold it until accepted
  task automatic issue(input logic [FUNC_W-1:0] f, input logic [SIZE_W-1:0] sz,
                       input logic [TIME_W-1:0] tm, input logic [HIT_W-1:0] hit);
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    req_valid <= 1'b1;
    req_func  <= f;
    req_size  <= sz;
    req_time  <= tm;
    req_hit   <= hit;
    @(posedge clk_i);
    while (req_if.ready !== 1'b1) @(posedge clk_i);
  endtask

  task automatic add_entry(input logic [SIZE_W-1:0] sz, input logic [TIME_W-1:0] tm);
    issue(FUNC_ADD, sz, tm, rand_hit());
  endtask

  task automatic hit_at(input logic [HIT_W-1:0] hit);
    issue(FUNC_HIT, rand_size(), rand_time(), hit);
  endtask

  task automatic schedule_next();
    issue(FUNC_SCHED, rand_size(), rand_time(), rand_hit());
  endtask

  // Grow and contest the winners, then drain the favoured entries
  task automatic contest_round(input int unsigned n_mix, input int unsigned n_sched);
    int unsigned pick;
    repeat (n_mix) begin
      pick = $urandom_range(99);
      if (pick < 30) add_entry(rand_size(), rand_time());
      else if (pick < 94) hit_at(rand_hit());
      else issue(FUNC_UNUSED, rand_size(), rand_time(), rand_hit());
    end
    repeat (n_sched) begin
      if ($urandom_range(99) < 8) issue(FUNC_UNUSED, rand_size(), rand_time(), rand_hit());
      else schedule_next();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Errors on an empty table and the unused selector
    schedule_next();
    hit_at(16'd7);
    issue(FUNC_UNUSED, 21'd0, 24'd0, 16'd0);

    // Dearest entry first, then cheaper and equal costs take over
    add_entry(21'(MAX_TC_SIZE), 24'hFFFFFF);
    hit_at(16'd0);
    hit_at(16'hFFFF);
    add_entry(21'd0, 24'd0);
    hit_at(16'd0);
    add_entry(21'd0, 24'd5);
    hit_at(16'd0);
    hit_at(16'hFFFF);
    add_entry(21'd3, 24'd7);
    hit_at(16'd1234);
    hit_at(16'd0);
    add_entry(21'h0AAAAA, 24'hAAAAAA);
    hit_at(16'hAAAA);
    add_entry(21'h055555, 24'h555555);
    hit_at(16'h5555);

    // Re-cull, search, cursor wrap and plain round-robin once the favoured ones are fuzzed
    repeat (6) schedule_next();
    issue(FUNC_UNUSED, 21'h0AAAAA, 24'hAAAAAA, 16'hAAAA);

    // Random rounds under each idling mix
    send_idle_pct = 0;  recv_stall_pct = 0;  contest_round(12, 8);
    send_idle_pct = 72; recv_stall_pct = 0;  contest_round(12, 8);
    send_idle_pct = 0;  recv_stall_pct = 72; contest_round(12, 8);
    send_idle_pct = 38; recv_stall_pct = 38; contest_round(12, 8);

    // Close with a schedule and a late hit
    schedule_next();
    hit_at(rand_hit());
    req_valid <= 1'b0;

    // Wait out the last results
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fails == 0) begin
      $display("tb_coverage_favored_entry_scheduler_unit OK");
    end else begin
      $display("tb_coverage_favored_entry_scheduler_unit NOT OK");
    end
    $finish;
  end

endmodule
